// ===== rtl/nta_pkg.sv =====
// ----------------------------------------------------------------------------
// nta_pkg: shared types and constants of the number to ASCII formatter
// Word formats, format action codes, BCD cell operations and state codes.
// ----------------------------------------------------------------------------
package nta_pkg;

  localparam int VALUE_W           = 32;
  localparam int CHAR_W            = 7;
  localparam int DIGIT_W           = 4;
  localparam int HEX_W             = 16;
  localparam int MAX_DEC_DIGITS    = 10;
  localparam int MAX_DEC_DIGITS_DEF = 10;

  // Format action codes
  localparam logic [1:0] ACT_DEC    = 2'd0;
  localparam logic [1:0] ACT_HEX2   = 2'd1;
  localparam logic [1:0] ACT_HEX4   = 2'd2;
  localparam logic [1:0] ACT_HEXMIN = 2'd3;

  // Thresholds for minimal hex width
  localparam logic [HEX_W-1:0] HEX_LIMIT_3 = 16'd4095;
  localparam logic [HEX_W-1:0] HEX_LIMIT_2 = 16'd255;
  localparam logic [HEX_W-1:0] HEX_LIMIT_1 = 16'd15;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_ALPHA = 7'd55;

  typedef struct packed {
    logic [1:0]         action;
    logic [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } out_word_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_SHIFT_DIGIT
  } cell_op_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] top_digit;
    logic               overflow;
  } chain_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT,
    ST_HEX
  } state_t;

  // Upper-case ASCII for one nibble
  function automatic logic [CHAR_W-1:0] hex_ascii(input logic [DIGIT_W-1:0] nib);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-DIGIT_W){1'b0}}, nib};
    return (nib < 4'd10) ? (ext + ASCII_ZERO) : (ext + ASCII_ALPHA);
  endfunction

endpackage

// ===== rtl/nta_bcd_cell.sv =====
// ----------------------------------------------------------------------------
// nta_bcd_cell: one decimal digit of the conversion chain
// Adds three when the digit is five or more, then shifts in a bit from the
// neighbour below; also passes whole digits upward for character output.
// ----------------------------------------------------------------------------
module nta_bcd_cell
  import nta_pkg::*;
(
  input  logic               clk,
  input  cell_op_t           op,
  input  logic               bit_in,
  input  logic [DIGIT_W-1:0] digit_in,
  output logic               bit_out,
  output logic [DIGIT_W-1:0] digit
);

  logic [DIGIT_W-1:0] adj;

  // Correct the digit before doubling
  assign adj     = (digit >= 4'd5) ? (digit + 4'd3) : digit;
  assign bit_out = adj[DIGIT_W-1];

  always_ff @(posedge clk) begin
    case (op)
      CELL_CLEAR:       digit <= '0;
      CELL_DABBLE:      digit <= {adj[DIGIT_W-2:0], bit_in};
      CELL_SHIFT_DIGIT: digit <= digit_in;
      default:          digit <= digit;
    endcase
  end

endmodule

// ===== rtl/nta_bcd_chain.sv =====
// ----------------------------------------------------------------------------
// nta_bcd_chain: row of BCD cells for binary to decimal conversion
// Cell 0 holds the least significant digit; the top cell feeds the output.
// Carries leaving the top cell mark that higher digits were dropped.
// ----------------------------------------------------------------------------
module nta_bcd_chain
  import nta_pkg::*;
#(
  parameter int NUM_CELLS = MAX_DEC_DIGITS
)
(
  input  logic          clk,
  input  cell_op_t      op,
  input  logic          bin_bit,
  output chain_status_t status
);

  logic [NUM_CELLS-1:0]              carry;
  logic [NUM_CELLS-1:0][DIGIT_W-1:0] digits;
  logic                              overflow;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    logic               bit_in;
    logic [DIGIT_W-1:0] digit_in;
    if (i == 0) begin : g_first
      assign bit_in   = bin_bit;
      assign digit_in = '0;
    end else begin : g_rest
      assign bit_in   = carry[i-1];
      assign digit_in = digits[i-1];
    end
    nta_bcd_cell u_cell (
      .clk      (clk),
      .op       (op),
      .bit_in   (bit_in),
      .digit_in (digit_in),
      .bit_out  (carry[i]),
      .digit    (digits[i])
    );
  end

  // Record any carry dropped off the top digit
  always_ff @(posedge clk) begin
    if (op == CELL_CLEAR) begin
      overflow <= 1'b0;
    end else if (op == CELL_DABBLE && carry[NUM_CELLS-1]) begin
      overflow <= 1'b1;
    end
  end

  assign status.top_digit = digits[NUM_CELLS-1];
  assign status.overflow  = overflow;

endmodule

// ===== rtl/number_to_ascii_formatter_top.sv =====
// ----------------------------------------------------------------------------
// number_to_ascii_formatter_top: number to ASCII character stream
// Formats a number as decimal or upper-case hex characters, most
// significant first, with last set on the final character.
// ----------------------------------------------------------------------------
// One number is handled at a time. A hex word is loaded, then its
// characters (two, four, or one to four) are emitted in turn. A decimal
// word is loaded, shifted through a row of BCD cells (shift-and-add-3,
// one input bit per cycle), then its leading zeros are dropped one at a
// time, and then its characters are emitted. Dropped zeros and characters
// always add up to the cell count, so with no output stall every decimal
// word takes the same time whatever its value. Output back-pressure stalls
// character emission; the next word is accepted once the final character
// of the current one sits in the output register. Digits beyond
// MAX_DECIMAL_DIGITS (clamped to 1..10) are cut off at the top, and the
// lower digits keep their zeros.
// ----------------------------------------------------------------------------
module number_to_ascii_formatter_top
  import nta_pkg::*;
#(
  parameter int MAX_DECIMAL_DIGITS = MAX_DEC_DIGITS_DEF
)
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int DEC_CELLS = (MAX_DECIMAL_DIGITS < 1) ? 1 :
                             (MAX_DECIMAL_DIGITS > MAX_DEC_DIGITS) ? MAX_DEC_DIGITS :
                             MAX_DECIMAL_DIGITS;
  localparam int REM_W  = $clog2(DEC_CELLS + 1);
  localparam int BCNT_W = $clog2(VALUE_W);
  localparam logic [BCNT_W-1:0] BCNT_LAST = BCNT_W'(VALUE_W - 1);
  localparam logic [REM_W-1:0]  REM_ONE   = REM_W'(1);

  state_t             state, state_next;
  cell_op_t           op;
  chain_status_t      status;
  logic [VALUE_W-1:0] bin, bin_next;
  logic [BCNT_W-1:0]  bcnt, bcnt_next;
  logic [REM_W-1:0]   rem, rem_next;
  logic [HEX_W-1:0]   hex, hex_next;
  logic [2:0]         hcnt, hcnt_next;
  logic               out_load;
  out_word_t          out_word_next;
  logic               can_load;
  logic [HEX_W-1:0]   low16;

  nta_bcd_chain #(.NUM_CELLS(DEC_CELLS)) u_chain (
    .clk     (clk),
    .op      (op),
    .bin_bit (bin[VALUE_W-1]),
    .status  (status)
  );

  assign in_ready = (state == ST_IDLE);
  assign can_load = !out_valid || out_ready;
  assign low16    = in_data.value[HEX_W-1:0];

  // State and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    bin  <= bin_next;
    bcnt <= bcnt_next;
    rem  <= rem_next;
    hex  <= hex_next;
    hcnt <= hcnt_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_data <= out_word_next;
    end
  end

  // Next state, cell operation and character selection
  always_comb begin
    state_next    = state;
    op            = CELL_HOLD;
    bin_next      = bin;
    bcnt_next     = bcnt;
    rem_next      = rem;
    hex_next      = hex;
    hcnt_next     = hcnt;
    out_load      = 1'b0;
    out_word_next = out_data;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_data.action)
            ACT_DEC: begin
              op         = CELL_CLEAR;
              bin_next   = in_data.value;
              bcnt_next  = '0;
              rem_next   = REM_W'(DEC_CELLS);
              state_next = ST_CONV;
            end
            ACT_HEX2: begin
              hex_next   = {in_data.value[7:0], 8'h00};
              hcnt_next  = 3'd2;
              state_next = ST_HEX;
            end
            ACT_HEX4: begin
              hex_next   = low16;
              hcnt_next  = 3'd4;
              state_next = ST_HEX;
            end
            ACT_HEXMIN: begin
              // Left-align the fewest nibbles that show the value
              if (low16 > HEX_LIMIT_3) begin
                hex_next  = low16;
                hcnt_next = 3'd4;
              end else if (low16 > HEX_LIMIT_2) begin
                hex_next  = {low16[11:0], 4'h0};
                hcnt_next = 3'd3;
              end else if (low16 > HEX_LIMIT_1) begin
                hex_next  = {low16[7:0], 8'h00};
                hcnt_next = 3'd2;
              end else begin
                hex_next  = {low16[3:0], 12'h000};
                hcnt_next = 3'd1;
              end
              state_next = ST_HEX;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_CONV: begin
        op        = CELL_DABBLE;
        bin_next  = {bin[VALUE_W-2:0], 1'b0};
        bcnt_next = bcnt + 1'b1;
        if (bcnt == BCNT_LAST) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop leading zeros, keeping at least one digit
        if (status.top_digit == '0 && rem != REM_ONE && !status.overflow) begin
          op       = CELL_SHIFT_DIGIT;
          rem_next = rem - 1'b1;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          out_load                = 1'b1;
          out_word_next.char_code = {{(CHAR_W-DIGIT_W){1'b0}}, status.top_digit} + ASCII_ZERO;
          out_word_next.last      = (rem == REM_ONE);
          op                      = CELL_SHIFT_DIGIT;
          rem_next                = rem - 1'b1;
          if (rem == REM_ONE) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_HEX: begin
        if (can_load) begin
          out_load                = 1'b1;
          out_word_next.char_code = hex_ascii(hex[HEX_W-1 -: DIGIT_W]);
          out_word_next.last      = (hcnt == 3'd1);
          hex_next                = {hex[HEX_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          hcnt_next               = hcnt - 1'b1;
          if (hcnt == 3'd1) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // A word taken in leaves the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != ST_IDLE))
    else $error("formatter idle right after accepting a word");

  // Characters are always decimal digits or upper-case hex letters
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.char_code >= 7'd48 && out_data.char_code <= 7'd57) ||
                   (out_data.char_code >= 7'd65 && out_data.char_code <= 7'd70)))
    else $error("character code out of range");

  // Decimal emission never runs with no digits left
  a_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT || state == ST_SKIP) |-> (rem != '0))
    else $error("decimal digit count exhausted during emission");

  // Hex emission never runs with no nibbles left
  a_hcnt_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HEX) |-> (hcnt != 3'd0 && hcnt <= 3'd4))
    else $error("hex nibble count out of range");

endmodule

// ===== sim/number_to_ascii_formatter_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_to_ascii_formatter_top_tb: self-checking bench of the ASCII formatter
// Feeds numbers in all four formats through the valid/ready input and checks
// every character and last flag against an in-bench formatter, with random
// idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module number_to_ascii_formatter_top_tb;
  import nta_pkg::*;

  localparam int DEC_DIGITS  = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 80;
  localparam int MAX_PRINTS  = 40;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  out_word_t expected_chars[$];
  int        err_count;
  int        chars_checked;
  int        words_sent;
  int        action_count[4];
  int        send_idle_pct;
  int        recv_idle_pct;
  int        recv_hold_left;
  int        cycles;

  number_to_ascii_formatter_top #(
    .MAX_DECIMAL_DIGITS(DEC_DIGITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Report one mismatch and count it
  task automatic report_mismatch(input string what);
    if (err_count < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    err_count++;
  endtask

  // ASCII code of one hex or decimal digit
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] nib);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-DIGIT_W){1'b0}}, nib};
    if (nib < 4'd10) begin
      return ext + ASCII_ZERO;
    end
    return ext + ASCII_ALPHA;
  endfunction

  function automatic void push_char(input logic [CHAR_W-1:0] code, input logic is_last);
    out_word_t c;
    c.char_code = code;
    c.last      = is_last;
    expected_chars.push_back(c);
  endfunction

  // Work out the characters of one word, most significant first
  function automatic void predict_chars(input in_word_t w);
    logic [VALUE_W-1:0] v;
    logic [HEX_W-1:0]   low16;
    logic [DIGIT_W-1:0] digs[DEC_DIGITS];
    int                 ndig;
    low16 = w.value[HEX_W-1:0];
    ndig  = 0;
    case (w.action)
      ACT_DEC: begin
        v = w.value;
        do begin
          digs[ndig] = DIGIT_W'(v % 10);
          v          = v / 10;
          ndig++;
        end while (v != 0 && ndig < DEC_DIGITS);
        for (int k = ndig - 1; k >= 0; k--) begin
          push_char(digit_char(digs[k]), k == 0);
        end
      end
      ACT_HEX2: begin
        ndig = 2;
      end
      ACT_HEX4: begin
        ndig = 4;
      end
      default: begin
        if (low16 > HEX_LIMIT_3) begin
          ndig = 4;
        end else if (low16 > HEX_LIMIT_2) begin
          ndig = 3;
        end else if (low16 > HEX_LIMIT_1) begin
          ndig = 2;
        end else begin
          ndig = 1;
        end
      end
    endcase
    if (w.action != ACT_DEC) begin
      for (int k = ndig - 1; k >= 0; k--) begin
        push_char(digit_char(DIGIT_W'(low16 >> (4 * k))), k == 0);
      end
    end
  endfunction

  // Offer one word and hold it until accepted
  task automatic send_word(input logic [1:0] act, input logic [VALUE_W-1:0] val);
    in_word_t w;
    int       gap;
    w.action = act;
    w.value  = val;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(4, 1) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    predict_chars(w);
    words_sent++;
    action_count[act]++;
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  // Values of every magnitude, from one nibble up to full width
  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    v = $urandom;
    if ($urandom_range(3) != 0) begin
      v = v >> $urandom_range(31, 0);
    end
    return v;
  endfunction

  // Drop the output ready at random, or for a long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold_left > 0) begin
        out_ready <= 1'b0;
        recv_hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each accepted character with the oldest expectation
  always @(posedge clk) begin
    out_word_t exp_c;
    if (!rst && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%0h last %0b",
                                  out_data.char_code, out_data.last));
      end else begin
        exp_c = expected_chars.pop_front();
        chars_checked++;
        if (out_data.char_code !== exp_c.char_code) begin
          report_mismatch($sformatf("char_code 0x%0h, expected 0x%0h",
                                    out_data.char_code, exp_c.char_code));
        end
        if (out_data.last !== exp_c.last) begin
          report_mismatch($sformatf("last %0b, expected %0b (char 0x%0h)",
                                    out_data.last, exp_c.last, exp_c.char_code));
        end
      end
    end
  end

  // Hard stop on a hang
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped after %0d cycles with %0d chars outstanding",
             cycles, expected_chars.size());
    $display("** number_to_ascii_formatter_top: FAILED **");
    $finish;
  end

  // Edge values, zeros and each width boundary of minimal hex
  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_word(ACT_DEC, 32'd0);
    send_word(ACT_DEC, 32'd9);
    send_word(ACT_DEC, 32'd10);
    send_word(ACT_DEC, 32'd999999999);
    send_word(ACT_DEC, 32'd1000000000);
    send_word(ACT_DEC, 32'hFFFF_FFFF);
    send_word(ACT_HEX2, 32'd0);
    send_word(ACT_HEX2, 32'hFFFF_FF0A);
    send_word(ACT_HEX2, 32'h0000_00F0);
    send_word(ACT_HEX2, 32'hFFFF_FFFF);
    send_word(ACT_HEX4, 32'd0);
    send_word(ACT_HEX4, 32'hABCD_1234);
    send_word(ACT_HEX4, 32'h0000_FFFF);
    send_word(ACT_HEX4, 32'h0000_9A0F);
    send_word(ACT_HEXMIN, 32'd0);
    send_word(ACT_HEXMIN, 32'hFFFF_0000);
    send_word(ACT_HEXMIN, 32'd15);
    send_word(ACT_HEXMIN, 32'd16);
    send_word(ACT_HEXMIN, 32'd255);
    send_word(ACT_HEXMIN, 32'd256);
    send_word(ACT_HEXMIN, 32'd4095);
    send_word(ACT_HEXMIN, 32'd4096);
    send_word(ACT_HEXMIN, 32'hFFFF_FFFF);
    go_idle();
    wait_drained();
  endtask

  // Random words under one idling mix
  task automatic test_random(input int n, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n) begin
      send_word(2'($urandom_range(3, 0)), random_value());
    end
    go_idle();
    wait_drained();
  endtask

  // Long output stall while words keep coming, then pause until drained
  task automatic test_output_stall();
    send_idle_pct  = 0;
    recv_idle_pct  = 20;
    recv_hold_left = 200;
    repeat (12) begin
      send_word(2'($urandom_range(3, 0)), random_value());
    end
    go_idle();
    wait_drained();
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    err_count      = 0;
    chars_checked  = 0;
    words_sent     = 0;
    action_count   = '{default: 0};
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    recv_hold_left = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random(130, 31, 50);
    test_output_stall();
    test_random(130, 50, 31);
    test_random(130, 0, 0);

    go_idle();
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_chars.size() != 0) begin
      report_mismatch($sformatf("%0d chars never arrived", expected_chars.size()));
    end
    $display("Formatted %0d words (dec %0d, hex2 %0d, hex4 %0d, min hex %0d), %0d chars",
             words_sent, action_count[ACT_DEC], action_count[ACT_HEX2],
             action_count[ACT_HEX4], action_count[ACT_HEXMIN], chars_checked);
    $display("Idling mixes 31/50, 50/31 and none, plus one long output stall; %0d errors",
             err_count);
    if (err_count == 0) begin
      $display("** number_to_ascii_formatter_top: PASSED **");
    end else begin
      $display("** number_to_ascii_formatter_top: FAILED **");
    end
    $finish;
  end

endmodule
